// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ASSERT_IMPLY_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sfr_pkg.sv =====
package sfr_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_MODE         = 3'd0,
    REG_PATTERN_BYTES      = 3'd1,
    REG_PATTERN_LENGTH     = 3'd2,
    REG_REPLACEMENT_BYTES  = 3'd3,
    REG_REPLACEMENT_LENGTH = 3'd4
  } cfg_reg_e;

  // Match mode codes; the unused fourth code behaves like MODE_ALL.
  localparam logic [1:0] MODE_FIRST   = 2'd0;
  localparam logic [1:0] MODE_ALL     = 2'd1;
  localparam logic [1:0] MODE_OVERLAP = 2'd2;

  typedef enum logic {
    FRONT_RUN,
    FRONT_FLUSH
  } front_state_e;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_PASS,
    TOK_REPL
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  data;
    logic        final_step;
    logic        end_mark;
  } token_t;

  localparam int unsigned TOK_W = $bits(token_t);

endpackage

// ===== design/sfr_if.sv =====
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last_result;

  modport source (output valid, output out_byte, output has_byte, output last_result,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input last_result,
                  output ready);
endinterface

interface sfr_cfg_if
  import sfr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== design/sfr_front.sv =====
module sfr_front
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 8,
  localparam int unsigned FW = $clog2(MAX_PATTERN + 1),
  localparam int unsigned SW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic [1:0]               mode_i,
  input  logic [8*MAX_PATTERN-1:0] pattern_i,
  input  logic [FW-1:0]            pat_len_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               in_byte_i,
  input  logic                     end_of_text_i,
  output logic                     tok_valid_o,
  input  logic                     tok_ready_i,
  output token_t                   tok_o
);

  front_state_e state_q, state_d;

  logic [7:0]           win_q [MAX_PATTERN];
  logic [7:0]           win_d [MAX_PATTERN];
  logic [7:0]           win_a [MAX_PATTERN];
  logic [7:0]           win_s [MAX_PATTERN];
  logic [FW-1:0]        fill_q, fill_d, fill_a, fill_s, thr;
  logic [SW-1:0]        skip_q, skip_d;
  logic                 first_q, first_d;
  logic                 accept, decide, hit, flush_end;
  logic [MAX_PATTERN-1:0] lane_ok;
  tok_kind_e            kind;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FRONT_RUN: begin
        if (accept && end_of_text_i) begin
          state_d = FRONT_FLUSH;
        end
      end
      FRONT_FLUSH: begin
        if (flush_end && tok_ready_i) begin
          state_d = FRONT_RUN;
        end
      end
      default: state_d = FRONT_RUN;
    endcase
  end

  always_comb begin
    thr        = (pat_len_i == '0) ? FW'(1) : pat_len_i;
    in_ready_o = (state_q == FRONT_RUN) && tok_ready_i;
    accept     = in_valid_i && in_ready_o;
    fill_a     = fill_q + FW'(1);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_a[k] = (fill_q == FW'(k)) ? in_byte_i : win_q[k];
    end

    // While running, the head is decided on the window with the new byte in it.
    if (state_q == FRONT_FLUSH) begin
      win_s  = win_q;
      fill_s = fill_q;
    end else begin
      win_s  = win_a;
      fill_s = fill_a;
    end

    for (int k = 0; k < MAX_PATTERN; k++) begin
      lane_ok[k] = (FW'(k) >= pat_len_i) || (win_s[k] == pattern_i[8*k +: 8]);
    end
    hit = (pat_len_i != '0) && (fill_s >= pat_len_i) &&
          ((mode_i != MODE_FIRST) || !first_q) && (&lane_ok);

    flush_end = (state_q == FRONT_FLUSH) && (fill_q == FW'(1));
    decide    = (state_q == FRONT_FLUSH) ? tok_ready_i
                                         : (accept && !end_of_text_i && (fill_a >= thr));

    if (skip_q != '0) begin
      kind = TOK_NONE;
    end else if (hit) begin
      kind = TOK_REPL;
    end else begin
      kind = TOK_PASS;
    end

    win_d   = win_q;
    fill_d  = fill_q;
    skip_d  = skip_q;
    first_d = first_q;
    if (decide) begin
      if (skip_q != '0) begin
        skip_d = skip_q - SW'(1);
      end else if (hit) begin
        skip_d  = (mode_i == MODE_OVERLAP) ? '0 : SW'(pat_len_i - FW'(1));
        first_d = 1'b1;
      end
      for (int k = 0; k < MAX_PATTERN - 1; k++) begin
        win_d[k] = win_s[k+1];
      end
      win_d[MAX_PATTERN-1] = '0;
      fill_d = fill_s - FW'(1);
    end else if (accept) begin
      win_d  = win_a;
      fill_d = fill_a;
    end

    // The end of a text and a new pattern length both start an empty stream.
    if ((flush_end && tok_ready_i) || (clear_i && (state_q == FRONT_RUN))) begin
      fill_d  = '0;
      skip_d  = '0;
      first_d = 1'b0;
    end

    tok_valid_o      = decide && ((kind != TOK_NONE) || flush_end);
    tok_o.kind       = kind;
    tok_o.data       = win_s[0];
    tok_o.final_step = (state_q == FRONT_FLUSH);
    tok_o.end_mark   = flush_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_RUN;
      fill_q  <= '0;
      skip_q  <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      skip_q  <= skip_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ===== design/sfr_fifo.sv =====
module sfr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  always_comb begin
    in_ready_o  = (cnt_q != CW'(DEPTH));
    out_valid_o = (cnt_q != '0);
    out_data_o  = mem_q[rptr_q];
    push        = in_valid_i && in_ready_o;
    pop         = out_valid_o && out_ready_i;

    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

endmodule

// ===== design/sfr_back.sv =====
module sfr_back
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_REPLACEMENT = 8,
  localparam int unsigned RW = $clog2(MAX_REPLACEMENT + 1),
  localparam int unsigned IW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [8*MAX_REPLACEMENT-1:0] replacement_i,
  input  logic [RW-1:0]                rep_len_i,
  input  logic                         tok_valid_i,
  output logic                         tok_ready_o,
  input  token_t                       tok_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         has_byte_o,
  output logic                         last_result_o
);

  logic [7:0]    rep_arr [MAX_REPLACEMENT];
  logic [RW-1:0] p_q, p_d, nb;
  logic [RW:0]   total;
  logic          slot_free, last_step, step, is_byte;
  logic [7:0]    gen_byte;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          has_q, has_d, last_q, last_d;
  logic          held_valid_q, held_valid_d;
  logic [7:0]    held_q, held_d;

  always_comb begin
    for (int k = 0; k < MAX_REPLACEMENT; k++) begin
      rep_arr[k] = replacement_i[8*k +: 8];
    end

    case (tok_i.kind)
      TOK_PASS: nb = RW'(1);
      TOK_REPL: nb = rep_len_i;
      default:  nb = '0;
    endcase
    // One step per emitted byte, plus one for the end of the text.
    total     = {1'b0, nb} + (RW+1)'(tok_i.end_mark);
    slot_free = !out_valid_q || out_ready_i;
    last_step = ({1'b0, p_q} == total - (RW+1)'(1));
    step      = tok_valid_i && (total != '0) && slot_free;
    tok_ready_o = tok_valid_i && ((total == '0) || (slot_free && last_step));
    is_byte   = (p_q < nb);
    gen_byte  = (tok_i.kind == TOK_PASS) ? tok_i.data : rep_arr[p_q[IW-1:0]];

    p_d          = p_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    has_d        = has_q;
    last_d       = last_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;

    if (step) begin
      p_d = last_step ? '0 : p_q + RW'(1);
      if (is_byte && !tok_i.final_step) begin
        out_valid_d = 1'b1;
        out_byte_d  = gen_byte;
        has_d       = 1'b1;
        last_d      = 1'b0;
      end else if (is_byte) begin
        // Bytes of the closing flush are held back one place so that the
        // final one can carry the last-result mark.
        if (held_valid_q) begin
          out_valid_d = 1'b1;
          out_byte_d  = held_q;
          has_d       = 1'b1;
          last_d      = 1'b0;
        end
        held_d       = gen_byte;
        held_valid_d = 1'b1;
      end else begin
        out_valid_d  = 1'b1;
        last_d       = 1'b1;
        out_byte_d   = held_valid_q ? held_q : 8'h00;
        has_d        = held_valid_q;
        held_valid_d = 1'b0;
      end
    end

    out_valid_o   = out_valid_q;
    out_byte_o    = out_byte_q;
    has_byte_o    = has_q;
    last_result_o = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q          <= '0;
      out_valid_q  <= 1'b0;
      held_valid_q <= 1'b0;
    end else begin
      p_q          <= p_d;
      out_valid_q  <= out_valid_d;
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    has_q      <= has_d;
    last_q     <= last_d;
    held_q     <= held_d;
  end

endmodule

// ===== design/stream_find_and_replace.sv =====
// Throughput: one text byte per cycle while the token queue has room; a replacement of R
// bytes holds the output side while they are emitted, and the end of a text closes the input
// for the flush of the window. A byte is settled once pattern-length bytes are held; its
// result goes into the token queue as the deciding byte is taken, and from there into the
// output register.
// Reset: match mode all non-overlapping, other registers zero, stream empty, no result valid.
module stream_find_and_replace
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN     = 8,
  parameter int unsigned MAX_REPLACEMENT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfr_in_if.sink     in_ch,
  sfr_out_if.source  out_ch,
  sfr_cfg_if.sink    cfg_ch
);

  localparam int unsigned FW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RW = $clog2(MAX_REPLACEMENT + 1);

  logic [1:0]                   mode_q;
  logic [8*MAX_PATTERN-1:0]     pat_q;
  logic [3:0]                   pat_len_q;
  logic [8*MAX_REPLACEMENT-1:0] rep_q;
  logic [3:0]                   rep_len_q;
  logic [FW-1:0]                pat_len_eff;
  logic [RW-1:0]                rep_len_eff;
  logic                         cfg_write, clear_stream;

  logic                         fq_in_valid, fq_in_ready, fq_out_valid, fq_out_ready;
  token_t                       front_tok, back_tok;
  logic [TOK_W-1:0]             fq_out_data;

  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid && cfg_ch.ready;
  assign clear_stream = cfg_write && (cfg_ch.reg_index == REG_PATTERN_LENGTH);

  // Lengths above the supported maximum saturate.
  assign pat_len_eff = (pat_len_q > 4'(MAX_PATTERN)) ? FW'(MAX_PATTERN) : FW'(pat_len_q);
  assign rep_len_eff = (rep_len_q > 4'(MAX_REPLACEMENT)) ? RW'(MAX_REPLACEMENT)
                                                         : RW'(rep_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_ALL;
      pat_q     <= '0;
      pat_len_q <= '0;
      rep_q     <= '0;
      rep_len_q <= '0;
    end else if (cfg_write) begin
      case (cfg_ch.reg_index)
        REG_MATCH_MODE:         mode_q    <= cfg_ch.wr_data[1:0];
        REG_PATTERN_BYTES:      pat_q     <= cfg_ch.wr_data[8*MAX_PATTERN-1:0];
        REG_PATTERN_LENGTH:     pat_len_q <= cfg_ch.wr_data[3:0];
        REG_REPLACEMENT_BYTES:  rep_q     <= cfg_ch.wr_data[8*MAX_REPLACEMENT-1:0];
        REG_REPLACEMENT_LENGTH: rep_len_q <= cfg_ch.wr_data[3:0];
        default: ;
      endcase
    end
  end

  sfr_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear_stream),
    .mode_i       (mode_q),
    .pattern_i    (pat_q),
    .pat_len_i    (pat_len_eff),
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .in_byte_i    (in_ch.in_byte),
    .end_of_text_i(in_ch.end_of_text),
    .tok_valid_o  (fq_in_valid),
    .tok_ready_i  (fq_in_ready),
    .tok_o        (front_tok)
  );

  sfr_fifo #(
    .WIDTH(TOK_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fq_in_valid),
    .in_ready_o (fq_in_ready),
    .in_data_i  (front_tok),
    .out_valid_o(fq_out_valid),
    .out_ready_i(fq_out_ready),
    .out_data_o (fq_out_data)
  );

  assign back_tok = token_t'(fq_out_data);

  sfr_back #(
    .MAX_REPLACEMENT(MAX_REPLACEMENT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .replacement_i(rep_q),
    .rep_len_i    (rep_len_eff),
    .tok_valid_i  (fq_out_valid),
    .tok_ready_o  (fq_out_ready),
    .tok_i        (back_tok),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_byte_o   (out_ch.out_byte),
    .has_byte_o   (out_ch.has_byte),
    .last_result_o(out_ch.last_result)
  );

endmodule

// ===== design/sfr_checker.sv =====
`include "assert_macros.svh"

module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_eot_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       has_byte_i,
  input logic       last_result_i
);

  // A stalled result stays offered.
  `ASSERT_IMPLY_NEXT(a_out_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // The flush after the final byte of a text keeps the input closed.
  `ASSERT_IMPLY_NEXT(a_flush_blocks, clk_i, rst_ni, in_valid_i && in_ready_i && in_eot_i, !in_ready_i, "input taken during end-of-text flush")

  // A result without a byte only ever closes a text.
  `ASSERT_ALWAYS(a_marker_last, clk_i, rst_ni, !(out_valid_i && !has_byte_i) || last_result_i, "end marker without last mark")

  `ASSERT_ALWAYS(a_marker_zero, clk_i, rst_ni, !(out_valid_i && !has_byte_i) || (out_byte_i == 8'h00), "end marker carries a byte")

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .in_eot_i     (in_ch.end_of_text),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_byte_i   (out_ch.out_byte),
  .has_byte_i   (out_ch.has_byte),
  .last_result_i(out_ch.last_result)
);
